// ----- rtl/core/flow_endpoint_hash_table_assert.svh -----
// Assertion macros used by the flow endpoint hash table controller.
`ifndef FLOW_ENDPOINT_HASH_TABLE_ASSERT_SVH
`define FLOW_ENDPOINT_HASH_TABLE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define FEHASH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define FEHASH_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/fehash_pkg.sv -----
`default_nettype none
package fehash_pkg;

    localparam int BUCKETS   = 256;
    localparam int WAYS      = 4;
    localparam int TAG_BITS  = 32;
    localparam int BKT_W     = $clog2(BUCKETS);
    localparam int PP_W      = 24;
    localparam logic [31:0] HASH_SEED = 32'd5381;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_ADD    = 1'b1;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_UPDATED  = 3'd2,
        ST_INSERTED = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef struct packed {
        logic load;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic                valid;
        logic [63:0]         addr_high;
        logic [63:0]         addr_low;
        logic [PP_W-1:0]     port_proto;
        logic [TAG_BITS-1:0] tag;
    } t_entry;

    typedef t_entry [WAYS-1:0] t_row;

    function automatic logic [31:0] le_word(input logic [31:0] be);
        return {be[7:0], be[15:8], be[23:16], be[31:24]};
    endfunction

    function automatic logic [BKT_W-1:0] bucket_of(input logic [63:0] hi,
                                                   input logic [63:0] lo);
        logic [31:0] h;
        logic [31:0] m;
        h = HASH_SEED ^ le_word(hi[63:32]) ^ le_word(hi[31:0])
                      ^ le_word(lo[63:32]) ^ le_word(lo[31:0]);
        m = h % BUCKETS;
        return m[BKT_W-1:0];
    endfunction

    function automatic logic [TAG_BITS-1:0] tag_from_input(input logic [31:0] t);
        logic [TAG_BITS+31:0] x;
        x = {{TAG_BITS{1'b0}}, t};
        return x[TAG_BITS-1:0];
    endfunction

    function automatic logic [31:0] tag_to_found(input logic [TAG_BITS-1:0] t);
        logic [TAG_BITS+31:0] x;
        x = {32'b0, t};
        return x[31:0];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/fehash_req_if.sv -----
`default_nettype none
interface fehash_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [15:0] port_number;
    logic [7:0]  protocol_number;
    logic [31:0] program_tag;

    modport source (
        output valid, operation, address_high, address_low,
               port_number, protocol_number, program_tag,
        input  ready
    );
    modport sink (
        input  valid, operation, address_high, address_low,
               port_number, protocol_number, program_tag,
        output ready
    );
endinterface
`default_nettype wire

// ----- rtl/core/fehash_rsp_if.sv -----
`default_nettype none
interface fehash_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] found_tag;

    modport source (
        output valid, status, found_tag,
        input  ready
    );
    modport sink (
        input  valid, status, found_tag,
        output ready
    );
endinterface
`default_nettype wire

// ----- rtl/core/fehash_ctrl.sv -----
`default_nettype none
`include "flow_endpoint_hash_table_assert.svh"
module fehash_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output fehash_pkg::t_dp_cmd o_cmd
);
    import fehash_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_COMMIT = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `FEHASH_ASSERT_NEXT(a_load_then_commit, o_cmd.load, r_state == S_COMMIT,
        "accepted transaction did not move to commit")
    `FEHASH_ASSERT_NEXT(a_commit_shows_result, o_cmd.commit, o_out_valid,
        "commit did not present a result")
    `FEHASH_ASSERT(a_no_overwrite,
        (r_out_valid && !i_out_ready) |-> !o_cmd.commit,
        "result overwritten while still pending")
    `FEHASH_ASSERT(a_cmd_exclusive, $onehot0({o_cmd.load, o_cmd.commit}),
        "load and commit in the same cycle")

endmodule
`default_nettype wire

// ----- rtl/core/fehash_dp.sv -----
`default_nettype none
module fehash_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fehash_pkg::t_dp_cmd i_cmd,
    input  logic                i_operation,
    input  logic [63:0]         i_address_high,
    input  logic [63:0]         i_address_low,
    input  logic [15:0]         i_port_number,
    input  logic [7:0]          i_protocol_number,
    input  logic [31:0]         i_program_tag,
    output logic [2:0]          o_status,
    output logic [31:0]         o_found_tag
);
    import fehash_pkg::*;

    t_row                r_mem [BUCKETS];
    t_row                r_rd_row;
    logic [BUCKETS-1:0]  r_row_init;

    logic                r_op;
    logic [63:0]         r_addr_high;
    logic [63:0]         r_addr_low;
    logic [PP_W-1:0]     r_pp;
    logic [TAG_BITS-1:0] r_tag;
    logic [BKT_W-1:0]    r_bucket;
    t_status             r_status;
    logic [31:0]         r_found;

    logic [BKT_W-1:0]    rd_idx;
    logic [WAYS-1:0]     valid_vec, hit_vec, free_vec, hit_1h, free_1h;
    logic                any_hit, any_free, wr_en;
    t_row                n_row;
    t_entry              n_ent;
    t_status             n_status;
    logic [31:0]         n_found;

    assign rd_idx = bucket_of(i_address_high, i_address_low);

    always_comb begin
        n_ent.valid      = 1'b1;
        n_ent.addr_high  = r_addr_high;
        n_ent.addr_low   = r_addr_low;
        n_ent.port_proto = r_pp;
        n_ent.tag        = r_tag;
        for (int w = 0; w < WAYS; w++) begin
            valid_vec[w] = r_row_init[r_bucket] & r_rd_row[w].valid;
            hit_vec[w]   = valid_vec[w]
                           && (r_rd_row[w].addr_high == r_addr_high)
                           && (r_rd_row[w].addr_low == r_addr_low)
                           && (r_rd_row[w].port_proto == r_pp);
        end
        free_vec = ~valid_vec;
        hit_1h   = hit_vec & (~hit_vec + WAYS'(1));
        free_1h  = free_vec & (~free_vec + WAYS'(1));
        any_hit  = |hit_vec;
        any_free = |free_vec;
        n_found  = '0;
        n_row    = r_rd_row;
        for (int w = 0; w < WAYS; w++) begin
            n_row[w].valid = valid_vec[w];
            if (hit_1h[w]) begin
                n_row[w].tag = r_tag;
                n_found      = n_found | tag_to_found(r_rd_row[w].tag);
            end else if (!any_hit && free_1h[w]) begin
                n_row[w] = n_ent;
            end
        end
        if (r_op == OP_LOOKUP) begin
            n_status = any_hit ? ST_HIT : ST_MISS;
        end else begin
            n_found = '0;
            if (any_hit) begin
                n_status = ST_UPDATED;
            end else if (any_free) begin
                n_status = ST_INSERTED;
            end else begin
                n_status = ST_FULL;
            end
        end
        wr_en = i_cmd.commit && (r_op == OP_ADD) && (any_hit || any_free);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd_row <= r_mem[rd_idx];
        end
        if (wr_en) begin
            r_mem[r_bucket] <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_init <= '0;
        end else if (wr_en) begin
            r_row_init[r_bucket] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= i_operation;
            r_addr_high <= i_address_high;
            r_addr_low  <= i_address_low;
            r_pp        <= {i_port_number, i_protocol_number};
            r_tag       <= tag_from_input(i_program_tag);
            r_bucket    <= rd_idx;
        end
        if (i_cmd.commit) begin
            r_status <= n_status;
            r_found  <= n_found;
        end
    end

    assign o_status    = r_status;
    assign o_found_tag = r_found;

endmodule
`default_nettype wire

// ----- rtl/core/flow_endpoint_hash_table.sv -----
// Each transaction is taken in S_IDLE, where its bucket row is read, and finished in
// S_COMMIT, where the compare and write-back happen once the output register is free;
// a new request is not accepted until the previous one has committed.
// A new request is taken while the previous result waits at the output register.
// Reset clears the controller, the output valid and one live bit per bucket;
// the table is empty right after reset, with no clearing pass.
`default_nettype none
module flow_endpoint_hash_table (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fehash_req_if.sink   i_req,
    fehash_rsp_if.source o_rsp
);
    import fehash_pkg::*;

    t_dp_cmd dp_cmd;

    fehash_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (dp_cmd)
    );

    fehash_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .i_operation       (i_req.operation),
        .i_address_high    (i_req.address_high),
        .i_address_low     (i_req.address_low),
        .i_port_number     (i_req.port_number),
        .i_protocol_number (i_req.protocol_number),
        .i_program_tag     (i_req.program_tag),
        .o_status          (o_rsp.status),
        .o_found_tag       (o_rsp.found_tag)
    );

endmodule
`default_nettype wire
